FILE: rtl/pur_pkg.sv
`default_nettype none
package pur_pkg;

    localparam int RANK_W     = 45;
    localparam int LEN_W      = 5;
    localparam int FIRST_W    = 32;
    localparam int VAL_W      = 33;
    localparam int POS_W      = 4;
    localparam int FACT_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PERM_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_VALUE = 1'd1;

    // one classified rank on its way to the back end
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [LEN_W-1:0]  len;
        logic              err;
    } t_cmd;

    // n! for n up to 20; codes above that are never looked up
    function automatic logic [FACT_W-1:0] fact_of(input logic [LEN_W-1:0] n);
        logic [FACT_W-1:0] f;
        case (n)
            5'd0:    f = 64'd1;
            5'd1:    f = 64'd1;
            5'd2:    f = 64'd2;
            5'd3:    f = 64'd6;
            5'd4:    f = 64'd24;
            5'd5:    f = 64'd120;
            5'd6:    f = 64'd720;
            5'd7:    f = 64'd5040;
            5'd8:    f = 64'd40320;
            5'd9:    f = 64'd362880;
            5'd10:   f = 64'd3628800;
            5'd11:   f = 64'd39916800;
            5'd12:   f = 64'd479001600;
            5'd13:   f = 64'd6227020800;
            5'd14:   f = 64'd87178291200;
            5'd15:   f = 64'd1307674368000;
            5'd16:   f = 64'd20922789888000;
            5'd17:   f = 64'd355687428096000;
            5'd18:   f = 64'd6402373705728000;
            5'd19:   f = 64'd121645100408832000;
            5'd20:   f = 64'd2432902008176640000;
            default: f = '1;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/permutation_unrank.sv
// A rank is registered in the front end and held in the command queue until the back end
// takes it; each position then counts its digit (the chosen entry's place in the unused list)
// by compare-subtract steps before its element word is loaded into the output register.
// The back end has a single compare-subtract unit and takes the next rank only when idle.
// A rank at or beyond L! yields a single error word and no elements.
// Reset (synchronous, active low) empties the pipeline and queue; perm_length=16, first_value=1.
`default_nettype none
module permutation_unrank #(
    parameter int MAX_LEN = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [pur_pkg::RANK_W-1:0]       i_rank,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [pur_pkg::POS_W-1:0]             o_position,
    output logic [pur_pkg::VAL_W-1:0]             o_element_value,
    output logic                                  o_rank_error,
    output logic                                  o_last,
    input  wire logic                             i_cfg_we,
    input  wire logic [pur_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pur_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [pur_pkg::LEN_W-1:0]   r_perm_length;
    logic [pur_pkg::FIRST_W-1:0] r_first_value;

    logic          push;
    logic          full;
    pur_pkg::t_cmd push_cmd;
    logic          q_valid;
    pur_pkg::t_cmd q_cmd;
    logic          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_length <= pur_pkg::LEN_W'(16);
            r_first_value <= pur_pkg::FIRST_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pur_pkg::REG_PERM_LENGTH: r_perm_length <= i_cfg_data[pur_pkg::LEN_W-1:0];
                pur_pkg::REG_FIRST_VALUE: r_first_value <= i_cfg_data[pur_pkg::FIRST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pur_front #(
        .MAX_LEN(MAX_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rank        (i_rank),
        .i_perm_length (r_perm_length),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    pur_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    pur_back #(
        .MAX_LEN(MAX_LEN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .i_first_value   (r_first_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_position      (o_position),
        .o_element_value (o_element_value),
        .o_rank_error    (o_rank_error),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

FILE: rtl/pur_front.sv
`default_nettype none
module pur_front #(
    parameter int MAX_LEN = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [pur_pkg::RANK_W-1:0]   i_rank,
    input  wire logic [pur_pkg::LEN_W-1:0]    i_perm_length,
    input  wire logic                         i_full,
    output logic                              o_push,
    output pur_pkg::t_cmd                     o_cmd
);

    logic                    r_valid;
    pur_pkg::t_cmd           r_cmd;
    logic                    n_valid;
    pur_pkg::t_cmd           n_cmd;
    logic [pur_pkg::LEN_W-1:0] eff_len;
    logic                    accept;

    always_comb begin
        if (i_perm_length == '0) begin
            eff_len = pur_pkg::LEN_W'(1);
        end else if (i_perm_length > pur_pkg::LEN_W'(MAX_LEN)) begin
            eff_len = pur_pkg::LEN_W'(MAX_LEN);
        end else begin
            eff_len = i_perm_length;
        end
    end

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid    = 1'b1;
            n_cmd.rank = i_rank;
            n_cmd.len  = eff_len;
            // flag ranks at or beyond len!
            n_cmd.err  = {{(pur_pkg::FACT_W-pur_pkg::RANK_W){1'b0}}, i_rank}
                         >= pur_pkg::fact_of(eff_len);
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

FILE: rtl/pur_fifo.sv
`default_nettype none
module pur_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pur_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output pur_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    pur_pkg::t_cmd r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid) && r_count != 2'd3)
        else $error("command queue over- or underflow");

endmodule
`default_nettype wire

FILE: rtl/pur_back.sv
`default_nettype none
module pur_back #(
    parameter int MAX_LEN = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire pur_pkg::t_cmd                 i_cmd,
    output logic                               o_pop,
    input  wire logic [pur_pkg::FIRST_W-1:0]   i_first_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pur_pkg::POS_W-1:0]          o_position,
    output logic [pur_pkg::VAL_W-1:0]          o_element_value,
    output logic                               o_rank_error,
    output logic                               o_last
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DIGIT = 1'b1;

    logic                          r_state;
    logic                          n_state;
    logic [pur_pkg::RANK_W-1:0]    r_rest;
    logic [pur_pkg::RANK_W-1:0]    n_rest;
    logic [pur_pkg::LEN_W-1:0]     r_len;
    logic [pur_pkg::LEN_W-1:0]     n_len;
    logic [IDX_W-1:0]              r_pos;
    logic [IDX_W-1:0]              n_pos;
    logic [IDX_W-1:0]              r_digit;
    logic [IDX_W-1:0]              n_digit;
    logic [IDX_W-1:0]              r_list [MAX_LEN];
    logic [IDX_W-1:0]              n_list [MAX_LEN];

    logic                          r_out_valid;
    logic [pur_pkg::POS_W-1:0]     r_out_pos;
    logic [pur_pkg::VAL_W-1:0]     r_out_val;
    logic                          r_out_err;
    logic                          r_out_last;

    logic                          out_free;
    logic                          out_load;
    logic [pur_pkg::POS_W-1:0]     load_pos;
    logic [pur_pkg::VAL_W-1:0]     load_val;
    logic                          load_err;
    logic                          load_last;
    logic [pur_pkg::LEN_W-1:0]     remaining;
    logic [pur_pkg::FACT_W-1:0]    fact;
    logic                          can_step;
    logic                          is_last;
    logic [IDX_W-1:0]              chosen;

    assign out_free  = !r_out_valid || !i_stall;
    assign remaining = r_len - pur_pkg::LEN_W'(r_pos);
    assign fact      = pur_pkg::fact_of(remaining - pur_pkg::LEN_W'(1));
    assign can_step  = ({{(pur_pkg::FACT_W-pur_pkg::RANK_W){1'b0}}, r_rest} >= fact)
                       && (pur_pkg::LEN_W'(r_digit) < remaining - pur_pkg::LEN_W'(1));
    assign is_last   = (pur_pkg::LEN_W'(r_pos) == r_len - pur_pkg::LEN_W'(1));
    assign chosen    = r_list[r_digit];

    always_comb begin
        n_state   = r_state;
        n_rest    = r_rest;
        n_len     = r_len;
        n_pos     = r_pos;
        n_digit   = r_digit;
        n_list    = r_list;
        o_pop     = 1'b0;
        out_load  = 1'b0;
        load_pos  = '0;
        load_val  = '0;
        load_err  = 1'b0;
        load_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.err) begin
                        // single error word, no elements
                        if (out_free) begin
                            o_pop     = 1'b1;
                            out_load  = 1'b1;
                            load_err  = 1'b1;
                            load_last = 1'b1;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_rest  = i_cmd.rank;
                        n_len   = i_cmd.len;
                        n_pos   = '0;
                        n_digit = '0;
                        for (int i = 0; i < MAX_LEN; i++) begin
                            n_list[i] = IDX_W'(i);
                        end
                        n_state = S_DIGIT;
                    end
                end
            end
            S_DIGIT: begin
                if (can_step) begin
                    // one compare-subtract per cycle builds the digit
                    n_rest  = r_rest - pur_pkg::RANK_W'(fact);
                    n_digit = r_digit + IDX_W'(1);
                end else if (out_free) begin
                    out_load  = 1'b1;
                    load_pos  = pur_pkg::POS_W'(r_pos);
                    load_val  = {1'b0, i_first_value} + pur_pkg::VAL_W'(chosen);
                    load_last = is_last;
                    // drop the chosen entry, close the gap
                    for (int i = 0; i < MAX_LEN - 1; i++) begin
                        if (IDX_W'(i) >= r_digit) begin
                            n_list[i] = r_list[i+1];
                        end
                    end
                    n_pos   = r_pos + IDX_W'(1);
                    n_digit = '0;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_rest  <= n_rest;
        r_len   <= n_len;
        r_pos   <= n_pos;
        r_digit <= n_digit;
        r_list  <= n_list;
        if (out_load) begin
            r_out_pos  <= load_pos;
            r_out_val  <= load_val;
            r_out_err  <= load_err;
            r_out_last <= load_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_position      = r_out_pos;
    assign o_element_value = r_out_val;
    assign o_rank_error    = r_out_err;
    assign o_last          = r_out_last;

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rank_error |-> o_last && o_position == '0 && o_element_value == '0)
        else $error("error word carries element data");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIGIT |-> pur_pkg::LEN_W'(r_digit) < remaining)
        else $error("digit past remaining count");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && load_last |=> r_state == S_IDLE)
        else $error("sequencer busy after last word");

endmodule
`default_nettype wire
